### design/multi_slot_fast_timer_service_unit_assert.svh
// Assertion macros used by the timer service unit.
`ifndef MULTI_SLOT_FAST_TIMER_SERVICE_UNIT_ASSERT_SVH
`define MULTI_SLOT_FAST_TIMER_SERVICE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSFTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/msfts_pkg.sv
// Shared types and constants of the timer service unit.
package msfts_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;

  localparam logic [15:0] MIN_COUNT_RST = 16'h0000;
  localparam logic [15:0] CEILING_RST   = 16'hFF00;
  localparam logic [7:0]  GUARD_RST     = 8'd20;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_COUNT = 2'd0;
  localparam logic [1:0] REG_CEILING   = 2'd1;
  localparam logic [1:0] REG_GUARD     = 2'd2;

  // Input action codes.
  localparam logic [1:0] ACT_SERVICE = 2'd0;
  localparam logic [1:0] ACT_ARM     = 2'd1;
  localparam logic [1:0] ACT_DISARM  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic        step;
    logic        write;
    logic        arm;
    logic [3:0]  slot;
    logic [7:0]  id;
    logic [30:0] period;
    logic        rep;
    logic [16:0] elapsed;
    logic [15:0] min_count;
  } cell_ctl_t;

  // Token and running minimum handed from cell to cell.
  typedef struct packed {
    logic               tok;
    logic signed [31:0] low;
  } link_t;

  // Per-cell status seen by the sequencer.
  typedef struct packed {
    logic       fire;
    logic [7:0] id;
    logic       active;
  } cell_stat_t;

endpackage

### design/multi_slot_fast_timer_service_unit.sv
// Timer service unit: a chain of slot cells, a sequencer and a result register.
// Each slot lives in a cell of a chain; a service item sends a token down the chain,
// one cell a cycle while the output can take a result, each cell subtracting the
// elapsed count, firing and reloading, and passing the smallest remaining count on. A
// service holds ready low from transfer while the token walks through the cells and
// the summary is loaded, and longer while a result waits at the output while the chain
// or the summary needs the result register. Arm, disarm and unused actions pass
// through the acknowledge state, and wait while an earlier result waits at the output.
// Results: one per fired slot in slot order, then a summary that carries last.
module multi_slot_fast_timer_service_unit #(
  parameter int NUM_SLOTS = msfts_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  slot,
  input  logic [7:0]  timer_id,
  input  logic [30:0] period,
  input  logic        repeat_req,
  input  logic [15:0] ref_count,
  input  logic [15:0] now_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  fired_id,
  output logic [15:0] next_compare,
  output logic        running,
  output logic        last
);

  `include "multi_slot_fast_timer_service_unit_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_ACK  = 4'b1000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic                 scan_go;
  logic [16:0]          elapsed;
  logic [15:0]          now_q;
  logic [15:0]          min_count;
  logic [15:0]          ceiling;
  logic [7:0]           guard;

  msfts_pkg::cell_ctl_t  ctl;
  msfts_pkg::link_t      links [NUM_SLOTS+1];
  msfts_pkg::cell_stat_t stats [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] fire_vec;
  logic [NUM_SLOTS-1:0] active_vec;
  logic [NUM_SLOTS:0]   tok_vec;
  logic [7:0]           fire_id;
  logic                 any_active;
  logic                 in_xfer;
  logic                 out_free;
  logic                 done_tok;
  logic                 step;
  logic                 slot_ok;
  logic [16:0]          floor_sum;
  logic [15:0]          floor_v;
  logic [15:0]          summary_cmp;
  logic                 load_fire;
  logic                 load_sum;
  logic                 load_ack;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign done_tok = links[NUM_SLOTS].tok;
  assign slot_ok  = (32'(slot) < NUM_SLOTS);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_count <= msfts_pkg::MIN_COUNT_RST;
      ceiling   <= msfts_pkg::CEILING_RST;
      guard     <= msfts_pkg::GUARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msfts_pkg::REG_MIN_COUNT: min_count <= cfg_data;
        msfts_pkg::REG_CEILING:   ceiling   <= cfg_data;
        msfts_pkg::REG_GUARD:     guard     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The chain only moves when a fired result has somewhere to go.
  always_comb begin
    step = 1'b0;
    unique case (state)
      ST_SCAN: step = out_free && !done_tok;
      ST_SUM:  step = out_free;
      default: step = 1'b0;
    endcase
  end

  // Broadcast control; arm and disarm write the addressed cell at the transfer.
  always_comb begin
    ctl.step      = step;
    ctl.write     = in_xfer && slot_ok &&
                    ((action == msfts_pkg::ACT_ARM) || (action == msfts_pkg::ACT_DISARM));
    ctl.arm       = (action == msfts_pkg::ACT_ARM);
    ctl.slot      = slot;
    ctl.id        = timer_id;
    ctl.period    = period;
    ctl.rep       = repeat_req;
    ctl.elapsed   = elapsed;
    ctl.min_count = min_count;
  end

  assign links[0] = '{tok: scan_go, low: $signed({16'b0, ceiling})};

  // The cell chain.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    msfts_cell #(
      .IDX(g)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .lin (links[g]),
      .lout(links[g+1]),
      .stat(stats[g])
    );
    assign fire_vec[g]   = stats[g].fire;
    assign active_vec[g] = stats[g].active;
  end

  for (genvar g = 0; g <= NUM_SLOTS; g++) begin : g_tok
    assign tok_vec[g] = links[g].tok;
  end

  // At most one cell fires in a cycle, so the ids combine by OR.
  always_comb begin
    fire_id = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (fire_vec[i]) begin
        fire_id = fire_id | stats[i].id;
      end
    end
  end

  assign any_active = |active_vec;

  // Next compare value: smallest remaining count, raised to the guarded floor, or ceiling.
  always_comb begin
    floor_sum = {1'b0, now_q} + {9'b0, guard};
    floor_v   = floor_sum[16] ? 16'hFFFF : floor_sum[15:0];
    if (!any_active) begin
      summary_cmp = ceiling;
    end else if (links[NUM_SLOTS].low < $signed({16'b0, floor_v})) begin
      summary_cmp = floor_v;
    end else begin
      summary_cmp = links[NUM_SLOTS].low[15:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (action == msfts_pkg::ACT_SERVICE) ? ST_SCAN : ST_ACK;
        end
      end
      ST_SCAN: begin
        if (done_tok) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      scan_go <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer && (action == msfts_pkg::ACT_SERVICE)) begin
        scan_go <= 1'b1;
      end else if (step) begin
        scan_go <= 1'b0;
      end
    end
  end

  // Service operands are sampled once, at the transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      elapsed <= {1'b0, ref_count} + {1'b0, now_count};
      now_q   <= now_count;
    end
  end

  assign load_fire = (state == ST_SCAN) && step && (|fire_vec);
  assign load_sum  = (state == ST_SUM) && out_free;
  assign load_ack  = (state == ST_ACK) && out_free;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fire || load_sum || load_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      kind         <= msfts_pkg::KIND_FIRED;
      fired_id     <= fire_id;
      next_compare <= '0;
      running      <= 1'b0;
      last         <= 1'b0;
    end else if (load_sum) begin
      kind         <= msfts_pkg::KIND_SUMMARY;
      fired_id     <= '0;
      next_compare <= summary_cmp;
      running      <= any_active;
      last         <= 1'b1;
    end else if (load_ack) begin
      kind         <= msfts_pkg::KIND_ACK;
      fired_id     <= '0;
      next_compare <= '0;
      running      <= any_active;
      last         <= 1'b1;
    end
  end

  `MSFTS_ASSERT_NOW(a_one_fire, 1'b1, $onehot0(fire_vec), "more than one cell fired")
  `MSFTS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec), "more than one token in chain")
  `MSFTS_ASSERT_NOW(a_fire_in_scan, |fire_vec, state == ST_SCAN, "cell fired outside a scan")
  `MSFTS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready, "ready held after a transfer")

endmodule

### design/msfts_cell.sv
// One timer slot cell of the service chain.
module msfts_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  msfts_pkg::cell_ctl_t  ctl,
  input  msfts_pkg::link_t      lin,
  output msfts_pkg::link_t      lout,
  output msfts_pkg::cell_stat_t stat
);

  logic               active;
  logic               rep;
  logic [7:0]         id;
  logic [30:0]        period;
  logic signed [31:0] rem;

  logic               sel;
  logic               process;
  logic signed [33:0] diff;
  logic signed [33:0] sum;
  logic signed [31:0] rem_sub;
  logic signed [31:0] rem_add;
  logic signed [31:0] rem_next;
  logic               hit;
  logic               active_next;

  assign sel     = (32'(ctl.slot) == IDX);
  assign process = ctl.step && lin.tok && active;

  // Subtract the elapsed count, saturating at the signed 32-bit range.
  always_comb begin
    diff = 34'(rem) - $signed({17'b0, ctl.elapsed});
    if (diff[33:31] != {3{diff[33]}}) begin
      rem_sub = diff[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rem_sub = diff[31:0];
    end
  end

  assign hit = (rem_sub <= $signed({16'b0, ctl.min_count}));

  // Reload adds the period back, again saturating.
  always_comb begin
    sum = 34'(rem_sub) + $signed({3'b0, period});
    if (sum[33:31] != {3{sum[33]}}) begin
      rem_add = sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rem_add = sum[31:0];
    end
  end

  assign rem_next    = (hit && rep) ? rem_add : rem_sub;
  assign active_next = !(hit && !rep);

  // Slot contents: loaded by arm, cleared by disarm, updated on service.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.write && sel) begin
      active <= ctl.arm;
    end else if (process) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write && sel) begin
      if (ctl.arm) begin
        id     <= ctl.id;
        period <= ctl.period;
        rem    <= $signed({1'b0, ctl.period});
        rep    <= ctl.rep;
      end else begin
        id     <= '0;
        period <= '0;
        rem    <= '0;
        rep    <= 1'b0;
      end
    end else if (process) begin
      rem <= rem_next;
    end
  end

  // Hand the token and the running minimum to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      lout.tok <= 1'b0;
    end else if (ctl.step) begin
      lout.tok <= lin.tok;
    end
    if (ctl.step && lin.tok) begin
      if (process && active_next && (rem_next < lin.low)) begin
        lout.low <= rem_next;
      end else begin
        lout.low <= lin.low;
      end
    end
  end

  assign stat.fire   = process && hit;
  assign stat.id     = id;
  assign stat.active = active;

endmodule
